/* rtl/core/owcd_pkg.sv */
// Package for the one-wire command dispatcher: queue sizing, action, mode
// and interrupt codes, and the command and status structs between the
// controller and the datapath. No dependencies.
package owcd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LEVEL_W     = 5;

    localparam logic [1:0] ACT_RESET = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_IRQ   = 2'd3;

    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_RESET   = 2'd1;
    localparam logic [1:0] MODE_WRITE   = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    localparam logic [1:0] IRQ_DEV_READY = 2'd0;
    localparam logic [1:0] IRQ_END_WRITE = 2'd1;

    typedef enum logic [1:0] {
        MSEL_KEEP,
        MSEL_ENGINE,
        MSEL_START
    } t_mode_sel;

    typedef struct packed {
        logic       capture;
        logic       commit;
        logic       push;
        logic       pop;
        logic       use_head;
        logic       drop;
        logic       finish_read;
        logic       clear_presence;
        logic       toggle_presence;
        logic [1:0] start_op;
        t_mode_sel  mode_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] irq_source;
        logic       read_done;
        logic       present;
        logic       mode_standby;
        logic       emode_standby;
        logic       q_empty;
        logic       q_full;
    } t_dp_status;

    // Ring pointer advance that also works for depths that are not a power of two.
    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/onewire_command_dispatcher.sv */
// One-wire command dispatcher, top level.
// Each beat steps through capture, queue head read and execute; the result
// is strobed by o_done in the cycle after execute, and a new beat can be started
// in that same cycle. The receiver cannot stall. Synchronous active-low reset
// returns to standby, clears presence and empties the queue; queue contents are
// not cleared.
module onewire_command_dispatcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic [1:0] i_irq_source,
    input  logic [1:0] i_engine_mode,
    input  logic       i_read_done,
    input  logic [7:0] i_read_byte,
    output logic       o_done,
    output logic       o_accepted,
    output logic       o_start_valid,
    output logic [1:0] o_start_mode,
    output logic [7:0] o_start_data,
    output logic       o_clear_read_flag,
    output logic [7:0] o_result_byte,
    output logic       o_dropped,
    output logic [owcd_pkg::LEVEL_W-1:0] o_queue_level,
    output logic       o_present,
    output logic [1:0] o_current_mode
);
    import owcd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    owcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    owcd_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_action          (i_action),
        .i_data_byte       (i_data_byte),
        .i_irq_source      (i_irq_source),
        .i_engine_mode     (i_engine_mode),
        .i_read_done       (i_read_done),
        .i_read_byte       (i_read_byte),
        .o_status          (status),
        .o_done            (o_done),
        .o_accepted        (o_accepted),
        .o_start_valid     (o_start_valid),
        .o_start_mode      (o_start_mode),
        .o_start_data      (o_start_data),
        .o_clear_read_flag (o_clear_read_flag),
        .o_result_byte     (o_result_byte),
        .o_dropped         (o_dropped),
        .o_queue_level     (o_queue_level),
        .o_present         (o_present),
        .o_current_mode    (o_current_mode)
    );

`ifndef SYNTHESIS
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while still busy");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_queue_level <= LEVEL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_start_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_start_valid || o_dropped || o_accepted) |-> o_done)
        else $error("result flag outside a result beat");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped) |-> (o_queue_level == LEVEL_W'(QUEUE_DEPTH)))
        else $error("byte dropped while queue not full");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");
`endif

endmodule

/* rtl/core/owcd_ctrl.sv */
// Controller of the one-wire command dispatcher: sequences each beat through
// fetch and execute and decodes the action into datapath commands.
// Depends on owcd_pkg.
module owcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  owcd_pkg::t_dp_status i_status,
    output owcd_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import owcd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   new_presence;
    logic   retry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_FETCH;
                        r_busy  <= 1'b1;
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign new_presence = (i_status.irq_source == IRQ_DEV_READY) ?
                          !i_status.present : i_status.present;
    assign retry = ((i_status.irq_source == IRQ_DEV_READY) ||
                    ((i_status.irq_source == IRQ_END_WRITE) && i_status.present)) &&
                   !i_status.q_empty;

    always_comb begin
        o_cmd          = '0;
        o_cmd.mode_sel = MSEL_KEEP;
        o_cmd.start_op = MODE_STANDBY;
        o_cmd.capture  = (r_state == ST_IDLE) && i_start;
        if (r_state == ST_EXEC) begin
            o_cmd.commit = 1'b1;
            unique case (i_status.action)
                ACT_RESET: begin
                    if (i_status.q_empty && i_status.mode_standby) begin
                        o_cmd.clear_presence = 1'b1;
                        o_cmd.start_op       = MODE_RESET;
                        o_cmd.mode_sel       = MSEL_START;
                    end
                end
                ACT_WRITE: begin
                    if (i_status.present && i_status.mode_standby) begin
                        o_cmd.start_op = MODE_WRITE;
                        o_cmd.mode_sel = MSEL_START;
                    end else if (i_status.q_full) begin
                        o_cmd.drop = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (i_status.present) begin
                        if (i_status.mode_standby) begin
                            o_cmd.start_op = MODE_READ;
                            o_cmd.mode_sel = MSEL_START;
                        end
                        // A finished read reloads the mode even when one was just started.
                        if (i_status.read_done) begin
                            o_cmd.finish_read = 1'b1;
                            o_cmd.mode_sel    = MSEL_ENGINE;
                        end
                    end
                end
                ACT_IRQ: begin
                    o_cmd.mode_sel        = MSEL_ENGINE;
                    o_cmd.toggle_presence = (i_status.irq_source == IRQ_DEV_READY);
                    if (retry) begin
                        o_cmd.pop      = 1'b1;
                        o_cmd.use_head = 1'b1;
                        if (new_presence && i_status.emode_standby) begin
                            o_cmd.start_op = MODE_WRITE;
                            o_cmd.mode_sel = MSEL_START;
                        end else begin
                            // The popped byte goes back to the tail; the pop left room.
                            o_cmd.push = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_busy = r_busy;

endmodule

/* rtl/core/owcd_dp.sv */
// Datapath of the one-wire command dispatcher: input capture, mode and
// presence registers, the pending byte ring queue and the result registers.
// Depends on owcd_pkg.
module owcd_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  owcd_pkg::t_dp_cmd    i_cmd,
    input  logic [1:0]           i_action,
    input  logic [7:0]           i_data_byte,
    input  logic [1:0]           i_irq_source,
    input  logic [1:0]           i_engine_mode,
    input  logic                 i_read_done,
    input  logic [7:0]           i_read_byte,
    output owcd_pkg::t_dp_status o_status,
    output logic                 o_done,
    output logic                 o_accepted,
    output logic                 o_start_valid,
    output logic [1:0]           o_start_mode,
    output logic [7:0]           o_start_data,
    output logic                 o_clear_read_flag,
    output logic [7:0]           o_result_byte,
    output logic                 o_dropped,
    output logic [owcd_pkg::LEVEL_W-1:0] o_queue_level,
    output logic                 o_present,
    output logic [1:0]           o_current_mode
);
    import owcd_pkg::*;

    logic [1:0]       r_action;
    logic [7:0]       r_data;
    logic [1:0]       r_irq;
    logic [1:0]       r_emode;
    logic             r_rdone;
    logic [7:0]       r_rbyte;

    logic [1:0]       r_mode;
    logic             r_presence;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_head;
    logic [7:0]       mem [QUEUE_DEPTH];

    logic [1:0]       n_mode;
    logic             n_presence;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       push_data;

    logic             r_done;
    logic             r_accepted;
    logic             r_start_valid;
    logic [1:0]       r_start_mode;
    logic [7:0]       r_start_data;
    logic             r_clear_read;
    logic [7:0]       r_result;
    logic             r_dropped;
    logic [LEVEL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_data   <= i_data_byte;
            r_irq    <= i_irq_source;
            r_emode  <= i_engine_mode;
            r_rdone  <= i_read_done;
            r_rbyte  <= i_read_byte;
        end
    end

    // The head entry is read every cycle; it is settled by the end of fetch.
    always_ff @(posedge i_clk) begin
        r_head <= mem[r_rd_ptr];
        if (i_cmd.push) begin
            mem[r_wr_ptr] <= push_data;
        end
    end

    assign push_data = i_cmd.use_head ? r_head : r_data;

    always_comb begin
        unique case (i_cmd.mode_sel)
            MSEL_KEEP:   n_mode = r_mode;
            MSEL_ENGINE: n_mode = r_emode;
            MSEL_START:  n_mode = i_cmd.start_op;
            default:     n_mode = r_mode;
        endcase
        n_presence = r_presence;
        if (i_cmd.clear_presence) begin
            n_presence = 1'b0;
        end else if (i_cmd.toggle_presence) begin
            n_presence = !r_presence;
        end
        n_count = r_count;
        if (i_cmd.push && !i_cmd.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STANDBY;
            r_presence    <= 1'b0;
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_count       <= '0;
            r_done        <= 1'b0;
            r_accepted    <= 1'b0;
            r_start_valid <= 1'b0;
            r_start_mode  <= MODE_STANDBY;
            r_start_data  <= '0;
            r_clear_read  <= 1'b0;
            r_result      <= '0;
            r_dropped     <= 1'b0;
            r_level       <= '0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_mode     <= n_mode;
                r_presence <= n_presence;
                r_count    <= n_count;
                if (i_cmd.pop) begin
                    r_rd_ptr <= next_ptr(r_rd_ptr);
                end
                if (i_cmd.push) begin
                    r_wr_ptr <= next_ptr(r_wr_ptr);
                end
                r_accepted    <= (i_cmd.start_op == MODE_RESET) || i_cmd.finish_read;
                r_start_valid <= (i_cmd.start_op != MODE_STANDBY);
                r_start_mode  <= i_cmd.start_op;
                r_start_data  <= (i_cmd.start_op == MODE_WRITE) ? push_data : 8'd0;
                r_clear_read  <= i_cmd.finish_read;
                r_result      <= i_cmd.finish_read ? r_rbyte : 8'd0;
                r_dropped     <= i_cmd.drop;
                r_level       <= LEVEL_W'(n_count);
            end else begin
                // The command and event flags are pulses that last only for the result cycle.
                r_accepted    <= 1'b0;
                r_start_valid <= 1'b0;
                r_clear_read  <= 1'b0;
                r_dropped     <= 1'b0;
            end
        end
    end

    assign o_status.action        = r_action;
    assign o_status.irq_source    = r_irq;
    assign o_status.read_done     = r_rdone;
    assign o_status.present       = r_presence;
    assign o_status.mode_standby  = (r_mode == MODE_STANDBY);
    assign o_status.emode_standby = (r_emode == MODE_STANDBY);
    assign o_status.q_empty       = (r_count == '0);
    assign o_status.q_full        = (r_count == CNT_W'(QUEUE_DEPTH));

    assign o_done            = r_done;
    assign o_accepted        = r_accepted;
    assign o_start_valid     = r_start_valid;
    assign o_start_mode      = r_start_mode;
    assign o_start_data      = r_start_data;
    assign o_clear_read_flag = r_clear_read;
    assign o_result_byte     = r_result;
    assign o_dropped         = r_dropped;
    assign o_queue_level     = r_level;
    assign o_present         = r_presence;
    assign o_current_mode    = r_mode;

endmodule

/* verif/onewire_command_dispatcher_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the one-wire command dispatcher: watches the command and result
// channels, predicts every result beat and compares it field by field.
// Depends on owcd_pkg for the action, mode and interrupt codes and the queue depth.
module onewire_command_dispatcher_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  logic [1:0] i_irq_source,
    input  logic [1:0] i_engine_mode,
    input  logic       i_read_done,
    input  logic [7:0] i_read_byte,
    input  logic       i_done,
    input  logic       i_accepted,
    input  logic       i_start_valid,
    input  logic [1:0] i_start_mode,
    input  logic [7:0] i_start_data,
    input  logic       i_clear_read_flag,
    input  logic [7:0] i_result_byte,
    input  logic       i_dropped,
    input  logic [owcd_pkg::LEVEL_W-1:0] i_queue_level,
    input  logic       i_present,
    input  logic [1:0] i_current_mode,
    output int         o_fail_count,
    output int         o_waiting
);
    import owcd_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic               start_valid;
        logic [1:0]         start_mode;
        logic [7:0]         start_data;
        logic               clear_read_flag;
        logic [7:0]         result_byte;
        logic               dropped;
        logic [LEVEL_W-1:0] queue_level;
        logic               present;
        logic [1:0]         current_mode;
    } step_result_t;

    step_result_t expected_beats[$];
    int fail_count = 0;
    int outstanding = 0;

    // Shadow copy of the dispatcher state.
    logic [1:0]  bus_mode;
    logic        bus_present;
    logic [7:0]  pend_mem [QUEUE_DEPTH];
    int unsigned pend_head;
    int unsigned pend_tail;
    int unsigned pend_count;

    assign o_fail_count = fail_count;
    assign o_waiting    = outstanding;

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        if (fail_count < 50) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got_v, want_v);
        end
        fail_count++;
    endtask

    function automatic int unsigned ring_next(input int unsigned p);
        return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    // A byte either starts a write at once or waits in the ring; a full ring loses it.
    function automatic void offer_byte(input logic [7:0] b, inout step_result_t r);
        if (bus_present && bus_mode == MODE_STANDBY) begin
            bus_mode      = MODE_WRITE;
            r.start_valid = 1'b1;
            r.start_mode  = MODE_WRITE;
            r.start_data  = b;
        end else if (pend_count >= QUEUE_DEPTH) begin
            r.dropped = 1'b1;
        end else begin
            pend_mem[pend_tail] = b;
            pend_tail = ring_next(pend_tail);
            pend_count++;
        end
    endfunction

    function automatic void retry_head(inout step_result_t r);
        logic [7:0] b;
        if (pend_count != 0) begin
            b = pend_mem[pend_head];
            pend_head = ring_next(pend_head);
            pend_count--;
            offer_byte(b, r);
        end
    endfunction

    function automatic step_result_t predict_step(input logic [1:0] act,
                                                  input logic [7:0] data,
                                                  input logic [1:0] src,
                                                  input logic [1:0] emode,
                                                  input logic rdone,
                                                  input logic [7:0] rbyte);
        step_result_t r;
        r = '0;
        case (act)
            ACT_RESET: begin
                if (pend_count == 0 && bus_mode == MODE_STANDBY) begin
                    bus_present   = 1'b0;
                    bus_mode      = MODE_RESET;
                    r.accepted    = 1'b1;
                    r.start_valid = 1'b1;
                    r.start_mode  = MODE_RESET;
                end
            end
            ACT_WRITE: begin
                offer_byte(data, r);
            end
            ACT_READ: begin
                // A poll may both start the read and collect it in the same beat.
                if (bus_present) begin
                    if (bus_mode == MODE_STANDBY) begin
                        bus_mode      = MODE_READ;
                        r.start_valid = 1'b1;
                        r.start_mode  = MODE_READ;
                    end
                    if (rdone) begin
                        r.clear_read_flag = 1'b1;
                        bus_mode          = emode;
                        r.result_byte     = rbyte;
                        r.accepted        = 1'b1;
                    end
                end
            end
            ACT_IRQ: begin
                bus_mode = emode;
                if (src == IRQ_DEV_READY) begin
                    bus_present = ~bus_present;
                    retry_head(r);
                end else if (bus_present && src == IRQ_END_WRITE) begin
                    retry_head(r);
                end
            end
            default: begin
            end
        endcase
        r.queue_level  = LEVEL_W'(pend_count);
        r.present      = bus_present;
        r.current_mode = bus_mode;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        step_result_t want;
        if (!i_rst_n) begin
            bus_mode    = MODE_STANDBY;
            bus_present = 1'b0;
            pend_head   = 0;
            pend_tail   = 0;
            pend_count  = 0;
            expected_beats.delete();
        end else begin
            // Results are checked before the beat accepted at the same edge is predicted.
            if (i_done) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 1, 0);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_accepted !== want.accepted)
                        report_mismatch("accepted", i_accepted, want.accepted);
                    if (i_start_valid !== want.start_valid)
                        report_mismatch("start_valid", i_start_valid, want.start_valid);
                    if (i_start_mode !== want.start_mode)
                        report_mismatch("start_mode", i_start_mode, want.start_mode);
                    if (i_start_data !== want.start_data)
                        report_mismatch("start_data", i_start_data, want.start_data);
                    if (i_clear_read_flag !== want.clear_read_flag)
                        report_mismatch("clear_read_flag", i_clear_read_flag,
                                        want.clear_read_flag);
                    if (i_result_byte !== want.result_byte)
                        report_mismatch("result_byte", i_result_byte, want.result_byte);
                    if (i_dropped !== want.dropped)
                        report_mismatch("dropped", i_dropped, want.dropped);
                    if (i_queue_level !== want.queue_level)
                        report_mismatch("queue_level", i_queue_level, want.queue_level);
                    if (i_present !== want.present)
                        report_mismatch("present", i_present, want.present);
                    if (i_current_mode !== want.current_mode)
                        report_mismatch("current_mode", i_current_mode, want.current_mode);
                end
            end
            if (i_start && !i_busy) begin
                expected_beats.push_back(predict_step(i_action, i_data_byte, i_irq_source,
                                                      i_engine_mode, i_read_done,
                                                      i_read_byte));
            end
        end
        outstanding = expected_beats.size();
    end

endmodule

/* verif/onewire_command_dispatcher_test.sv */
`timescale 1ns / 1ps
// Top of the one-wire command dispatcher testbench: clock, reset, directed and
// random command beats, watchdog and verdict. Uses owcd_pkg, the dispatcher and
// onewire_command_dispatcher_checker.
module onewire_command_dispatcher_test;
    import owcd_pkg::*;

    localparam logic [1:0] IRQ_OTHER    = 2'd2;
    localparam logic [1:0] IRQ_SPARE    = 2'd3;
    localparam int         RANDOM_BEATS = 1700;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 12;

    typedef enum int {
        PROF_MIX,
        PROF_FILL,
        PROF_DRAIN,
        PROF_READS
    } profile_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] i_action = ACT_RESET;
    logic [7:0] i_data_byte = 8'h00;
    logic [1:0] i_irq_source = IRQ_DEV_READY;
    logic [1:0] i_engine_mode = MODE_STANDBY;
    logic       i_read_done = 1'b0;
    logic [7:0] i_read_byte = 8'h00;

    logic       busy;
    logic       o_done;
    logic       o_accepted;
    logic       o_start_valid;
    logic [1:0] o_start_mode;
    logic [7:0] o_start_data;
    logic       o_clear_read_flag;
    logic [7:0] o_result_byte;
    logic       o_dropped;
    logic [LEVEL_W-1:0] o_queue_level;
    logic       o_present;
    logic [1:0] o_current_mode;

    int   fail_count;
    int   waiting;
    int   idle_cycles = 0;
    logic idle_on = 1'b1;

    onewire_command_dispatcher dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_data_byte       (i_data_byte),
        .i_irq_source      (i_irq_source),
        .i_engine_mode     (i_engine_mode),
        .i_read_done       (i_read_done),
        .i_read_byte       (i_read_byte),
        .o_done            (o_done),
        .o_accepted        (o_accepted),
        .o_start_valid     (o_start_valid),
        .o_start_mode      (o_start_mode),
        .o_start_data      (o_start_data),
        .o_clear_read_flag (o_clear_read_flag),
        .o_result_byte     (o_result_byte),
        .o_dropped         (o_dropped),
        .o_queue_level     (o_queue_level),
        .o_present         (o_present),
        .o_current_mode    (o_current_mode)
    );

    onewire_command_dispatcher_checker scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_action          (i_action),
        .i_data_byte       (i_data_byte),
        .i_irq_source      (i_irq_source),
        .i_engine_mode     (i_engine_mode),
        .i_read_done       (i_read_done),
        .i_read_byte       (i_read_byte),
        .i_done            (o_done),
        .i_accepted        (o_accepted),
        .i_start_valid     (o_start_valid),
        .i_start_mode      (o_start_mode),
        .i_start_data      (o_start_data),
        .i_clear_read_flag (o_clear_read_flag),
        .i_result_byte     (o_result_byte),
        .i_dropped         (o_dropped),
        .i_queue_level     (o_queue_level),
        .i_present         (o_present),
        .i_current_mode    (o_current_mode),
        .o_fail_count      (fail_count),
        .o_waiting         (waiting)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Ends the run when neither a command nor a result beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("onewire_command_dispatcher_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Start stays high across back-to-back beats, so it is only lowered for a gap.
    task automatic send_beat(input logic [1:0] act, input logic [7:0] data,
                             input logic [1:0] src, input logic [1:0] emode,
                             input logic rdone, input logic [7:0] rbyte);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_data_byte   <= data;
        i_irq_source  <= src;
        i_engine_mode <= emode;
        i_read_done   <= rdone;
        i_read_byte   <= rbyte;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_random(input profile_t prof);
        logic [1:0] act;
        logic [1:0] src;
        logic [1:0] emode;
        int         pick;
        pick = $urandom_range(0, 99);
        case (prof)
            PROF_FILL:
                act = (pick < 75) ? ACT_WRITE : (pick < 88) ? ACT_IRQ :
                      (pick < 94) ? ACT_READ : ACT_RESET;
            PROF_DRAIN:
                act = (pick < 70) ? ACT_IRQ : (pick < 80) ? ACT_WRITE :
                      (pick < 90) ? ACT_READ : ACT_RESET;
            PROF_READS:
                act = (pick < 50) ? ACT_READ : (pick < 80) ? ACT_IRQ :
                      (pick < 90) ? ACT_WRITE : ACT_RESET;
            default:
                act = (pick < 35) ? ACT_WRITE : (pick < 65) ? ACT_IRQ :
                      (pick < 85) ? ACT_READ : ACT_RESET;
        endcase
        // Draining leans on end-of-write so that presence does not flip on every beat.
        pick = $urandom_range(0, 99);
        if (prof == PROF_DRAIN) begin
            src = (pick < 25) ? IRQ_DEV_READY : (pick < 95) ? IRQ_END_WRITE :
                  ($urandom_range(0, 1) ? IRQ_OTHER : IRQ_SPARE);
        end else begin
            src = (pick < 45) ? IRQ_DEV_READY : (pick < 90) ? IRQ_END_WRITE :
                  ($urandom_range(0, 1) ? IRQ_OTHER : IRQ_SPARE);
        end
        emode = ($urandom_range(0, 99) < 70) ? MODE_STANDBY : 2'($urandom_range(0, 3));
        send_beat(act, 8'($urandom), src, emode, 1'($urandom), 8'($urandom));
    endtask

    initial begin
        int       sent;
        int       seg_len;
        profile_t prof;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: reset accepted, then refused while the mode is not standby.
        send_beat(ACT_RESET, 8'h00, IRQ_DEV_READY, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_RESET, 8'hFF, IRQ_DEV_READY, MODE_STANDBY, 1'b1, 8'hFF);
        // With no device present every write queues; the seventeenth is dropped.
        send_beat(ACT_WRITE, 8'h00, IRQ_DEV_READY, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_WRITE, 8'hFF, IRQ_END_WRITE, MODE_READ, 1'b1, 8'hFF);
        repeat (15) send_beat(ACT_WRITE, 8'($urandom), IRQ_DEV_READY, MODE_STANDBY,
                              1'b0, 8'h00);
        send_beat(ACT_IRQ, 8'h5A, IRQ_OTHER, MODE_STANDBY, 1'b1, 8'hFF);
        // Standby now, but the queue still holds bytes.
        send_beat(ACT_RESET, 8'h00, IRQ_DEV_READY, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_IRQ, 8'h00, IRQ_END_WRITE, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_READ, 8'h00, IRQ_DEV_READY, MODE_STANDBY, 1'b1, 8'hFF);
        send_beat(ACT_IRQ, 8'h00, IRQ_DEV_READY, MODE_STANDBY, 1'b0, 8'h00);
        // Engine busy with a reset: the popped byte goes back to the tail.
        send_beat(ACT_IRQ, 8'h00, IRQ_END_WRITE, MODE_RESET, 1'b0, 8'h00);
        send_beat(ACT_IRQ, 8'h00, IRQ_END_WRITE, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_IRQ, 8'h00, IRQ_SPARE, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_READ, 8'h00, IRQ_DEV_READY, MODE_WRITE, 1'b1, 8'h00);
        send_beat(ACT_IRQ, 8'h00, IRQ_OTHER, MODE_STANDBY, 1'b0, 8'h00);
        send_beat(ACT_READ, 8'h00, IRQ_DEV_READY, MODE_READ, 1'b0, 8'h00);
        send_beat(ACT_READ, 8'h00, IRQ_DEV_READY, MODE_STANDBY, 1'b1, 8'hA5);
        send_beat(ACT_WRITE, 8'h3C, IRQ_DEV_READY, MODE_STANDBY, 1'b0, 8'h00);

        // Random segments, each with its own action mix and gap behavior.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            prof    = profile_t'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 60);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (seg_len) send_random(prof);
            sent += seg_len;
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && waiting == 0) begin
            $display("onewire_command_dispatcher_test passed");
        end else begin
            $display("onewire_command_dispatcher_test failed");
        end
        $finish;
    end

endmodule
